FILE: rtl/core/ile_pkg.sv
package ile_pkg;

  // fixed field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned FOUND_W = 6;
  localparam int unsigned COUNT_W = 7;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR         = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND          = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAST_REMOVE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STABLE_REMOVE = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND_CHK,
    ST_FIND_CMP,
    ST_FR_WR,
    ST_SR_CHK,
    ST_SR_WR,
    ST_RESP
  } state_t;

  // read address source
  typedef enum logic {
    RD_IDX,
    RD_LAST
  } rd_sel_t;

  // write address and data source
  typedef enum logic [1:0] {
    WR_APPEND,
    WR_FAST,
    WR_STABLE
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    idx_zero;
    logic    idx_pos1;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    res_load;
    logic    res_ok;
    logic    res_found;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              room;
    logic              pos_ok;
    logic              idx_lt_fill;
    logic              match;
  } dp_status_t;

endpackage

FILE: rtl/core/ile_ctrl.sv
module ile_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ile_pkg::dp_status_t sts,
  output ile_pkg::ctrl_cmd_t  cmd,
  output logic               busy,
  output logic               res_strobe
);

  ile_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ile_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ile_pkg::ST_IDLE: begin
        if (start) state_nxt = ile_pkg::ST_DISPATCH;
      end
      ile_pkg::ST_DISPATCH: begin
        unique case (sts.kind)
          ile_pkg::KIND_FIND: state_nxt = ile_pkg::ST_FIND_CHK;
          ile_pkg::KIND_FAST_REMOVE: begin
            state_nxt = sts.pos_ok ? ile_pkg::ST_FR_WR : ile_pkg::ST_RESP;
          end
          ile_pkg::KIND_STABLE_REMOVE: begin
            state_nxt = sts.pos_ok ? ile_pkg::ST_SR_CHK : ile_pkg::ST_RESP;
          end
          default: state_nxt = ile_pkg::ST_RESP;
        endcase
      end
      ile_pkg::ST_FIND_CHK: begin
        state_nxt = sts.idx_lt_fill ? ile_pkg::ST_FIND_CMP : ile_pkg::ST_RESP;
      end
      ile_pkg::ST_FIND_CMP: begin
        state_nxt = sts.match ? ile_pkg::ST_RESP : ile_pkg::ST_FIND_CHK;
      end
      ile_pkg::ST_FR_WR: state_nxt = ile_pkg::ST_RESP;
      ile_pkg::ST_SR_CHK: begin
        state_nxt = sts.idx_lt_fill ? ile_pkg::ST_SR_WR : ile_pkg::ST_RESP;
      end
      ile_pkg::ST_SR_WR: state_nxt = ile_pkg::ST_SR_CHK;
      ile_pkg::ST_RESP:  state_nxt = ile_pkg::ST_IDLE;
      default:           state_nxt = ile_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = ile_pkg::RD_IDX;
    cmd.wr_sel = ile_pkg::WR_APPEND;
    unique case (state_r)
      ile_pkg::ST_IDLE: begin
        cmd.latch = start;
      end
      ile_pkg::ST_DISPATCH: begin
        cmd.res_load = 1'b1;
        unique case (sts.kind)
          ile_pkg::KIND_APPEND: begin
            cmd.wr_en   = sts.room;
            cmd.wr_sel  = ile_pkg::WR_APPEND;
            cmd.cnt_inc = sts.room;
            cmd.res_ok  = sts.room;
          end
          ile_pkg::KIND_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.res_ok  = 1'b1;
          end
          ile_pkg::KIND_FIND: begin
            cmd.idx_zero = 1'b1;
          end
          ile_pkg::KIND_FAST_REMOVE: begin
            cmd.rd_en  = sts.pos_ok;
            cmd.rd_sel = ile_pkg::RD_LAST;
          end
          ile_pkg::KIND_STABLE_REMOVE: begin
            cmd.idx_pos1 = sts.pos_ok;
          end
          default: begin
            cmd.res_ok = 1'b0;
          end
        endcase
      end
      ile_pkg::ST_FIND_CHK: begin
        cmd.rd_en  = sts.idx_lt_fill;
        cmd.rd_sel = ile_pkg::RD_IDX;
      end
      ile_pkg::ST_FIND_CMP: begin
        cmd.res_load  = sts.match;
        cmd.res_ok    = sts.match;
        cmd.res_found = sts.match;
        cmd.idx_inc   = !sts.match;
      end
      ile_pkg::ST_FR_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ile_pkg::WR_FAST;
        cmd.cnt_dec  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_ok   = 1'b1;
      end
      ile_pkg::ST_SR_CHK: begin
        cmd.rd_en    = sts.idx_lt_fill;
        cmd.rd_sel   = ile_pkg::RD_IDX;
        cmd.cnt_dec  = !sts.idx_lt_fill;
        cmd.res_load = !sts.idx_lt_fill;
        cmd.res_ok   = !sts.idx_lt_fill;
      end
      ile_pkg::ST_SR_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ile_pkg::WR_STABLE;
        cmd.idx_inc = 1'b1;
      end
      ile_pkg::ST_RESP: begin
        cmd.latch = 1'b0;
      end
      default: begin
        cmd.latch = 1'b0;
      end
    endcase
  end

  assign busy       = (state_r != ile_pkg::ST_IDLE);
  assign res_strobe = (state_r == ile_pkg::ST_RESP);

endmodule

FILE: rtl/core/ile_dp.sv
module ile_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ile_pkg::ctrl_cmd_t                  cmd,
  input  logic [ile_pkg::KIND_W-1:0]          kind,
  input  logic signed [ile_pkg::VALUE_W-1:0]  value,
  input  logic [ile_pkg::POS_W-1:0]           position,
  output ile_pkg::dp_status_t                 sts,
  output logic                                res_ok,
  output logic [ile_pkg::FOUND_W-1:0]         res_found_at,
  output logic [ile_pkg::COUNT_W-1:0]         res_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

  logic signed [ile_pkg::VALUE_W-1:0] entries_r [CAPACITY];
  logic signed [ile_pkg::VALUE_W-1:0] rdata_r;

  logic [ile_pkg::KIND_W-1:0]          kind_r;
  logic signed [ile_pkg::VALUE_W-1:0]  value_r;
  logic [ile_pkg::POS_W-1:0]           pos_r;
  logic [CW-1:0]                       fill_r, fill_nxt;
  logic [CW-1:0]                       idx_r, idx_nxt;
  logic                                ok_r;
  logic [ile_pkg::FOUND_W-1:0]         found_r;

  logic [EW-1:0]                       pos_ext;
  logic [CW-1:0]                       fill_m1;
  logic [CW-1:0]                       idx_m1;
  logic [AW-1:0]                       raddr;
  logic [AW-1:0]                       waddr;
  logic signed [ile_pkg::VALUE_W-1:0]  wdata;

  assign pos_ext = EW'(pos_r);
  assign fill_m1 = fill_r - CW'(1);
  assign idx_m1  = idx_r - CW'(1);

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= kind;
      value_r <= value;
      pos_r   <= position;
    end
  end

  // fill count
  always_comb begin
    priority if (cmd.cnt_clr) fill_nxt = '0;
    else if (cmd.cnt_inc)     fill_nxt = fill_r + CW'(1);
    else if (cmd.cnt_dec)     fill_nxt = fill_m1;
    else                      fill_nxt = fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // scan index
  always_comb begin
    priority if (cmd.idx_zero) idx_nxt = '0;
    else if (cmd.idx_pos1)     idx_nxt = CW'(pos_ext + EW'(1));
    else if (cmd.idx_inc)      idx_nxt = idx_r + CW'(1);
    else                       idx_nxt = idx_r;
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // entry memory, one write and one registered read per cycle
  always_comb begin
    unique case (cmd.rd_sel)
      ile_pkg::RD_LAST: raddr = fill_m1[AW-1:0];
      default:          raddr = idx_r[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      ile_pkg::WR_FAST: begin
        waddr = pos_ext[AW-1:0];
        wdata = rdata_r;
      end
      ile_pkg::WR_STABLE: begin
        waddr = idx_m1[AW-1:0];
        wdata = rdata_r;
      end
      default: begin
        waddr = fill_r[AW-1:0];
        wdata = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) entries_r[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= entries_r[raddr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      ok_r    <= cmd.res_ok;
      found_r <= cmd.res_found ? ile_pkg::FOUND_W'(idx_r) : '0;
    end
  end

  assign sts.kind        = kind_r;
  assign sts.room        = (fill_r < CW'(CAPACITY));
  assign sts.pos_ok      = (pos_ext < EW'(fill_r));
  assign sts.idx_lt_fill = (idx_r < fill_r);
  assign sts.match       = (rdata_r == value_r);

  assign res_ok       = ok_r;
  assign res_found_at = found_r;
  assign res_count    = ile_pkg::COUNT_W'(fill_r);

endmodule

FILE: rtl/core/integer_list_engine_top.sv
// channel   | ports                                      | handshake
// ----------+--------------------------------------------+---------------------------------
// request   | start, busy, in_kind, in_value, in_position | taken when start high, busy low
// result    | out_valid, out_ok, out_found_at, out_count | one-cycle strobe, never held off
//
// item sequence: append, clear, unused kinds and failed removals go from dispatch straight
// to the result; fast remove reads the last entry, then writes it over the removed position;
// find and stable remove walk the entries, each entry costing a read of the registered entry
// memory, then a compare (find) or a write (stable remove)
// reset: synchronous, active low; clears the fill count and the controller, not the entries
// busy stays high from accept through the result strobe; results cannot stall
module integer_list_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request item
  input  logic                                start,
  output logic                                busy,
  input  logic [ile_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [ile_pkg::VALUE_W-1:0]  in_value,
  input  logic [ile_pkg::POS_W-1:0]           in_position,
  // result item
  output logic                                out_valid,
  output logic                                out_ok,
  output logic [ile_pkg::FOUND_W-1:0]         out_found_at,
  output logic [ile_pkg::COUNT_W-1:0]         out_count
);

  // command and status between controller and datapath
  ile_pkg::ctrl_cmd_t  cmd;
  ile_pkg::dp_status_t sts;

  // sequencer: one item in flight at a time
  ile_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .res_strobe (out_valid)
  );

  // entry memory, fill count, scan index and result registers
  ile_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .kind         (in_kind),
    .value        (in_value),
    .position     (in_position),
    .sts          (sts),
    .res_ok       (out_ok),
    .res_found_at (out_found_at),
    .res_count    (out_count)
  );

  // an accepted item makes the block busy on the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // each item gives a single strobe, then the block returns to idle
  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe lasted more than one cycle");

  // a miss or failure never reports a position
  a_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_found_at == '0))
    else $error("found_at nonzero on failed result");

  // the count only moves while an item is being worked on
  a_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> $stable(out_count))
    else $error("count changed while idle");

endmodule
